/* src/svs_pkg.sv */
// ----------------------------------------------------------------------------
// svs_pkg: shared definitions of the sorted value store
// Capacity, derived widths, operation codes and the control bundle that the
// top level broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package svs_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = 6;
    localparam int COUNT_W  = 7;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int EXT_W    = CNT_W + COUNT_W;

    typedef enum logic [1:0] {
        OP_INSERT     = 2'd0,
        OP_REMOVE_AT  = 2'd1,
        OP_REMOVE_VAL = 2'd2,
        OP_READ       = 2'd3
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
        logic [CMP_W-1:0]         index;
        logic [CMP_W-1:0]         count;
        logic                     commit;
    } cell_ctl_t;

endpackage

/* src/svs_req_if.sv */
// ----------------------------------------------------------------------------
// svs_req_if: request channel of the sorted value store
// Valid/ready channel carrying one operation with its value and index.
// ----------------------------------------------------------------------------
interface svs_req_if;

    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [31:0] value;
    logic [5:0]         index;

    modport source (output valid, output opcode, output value, output index, input ready);
    modport sink   (input valid, input opcode, input value, input index, output ready);

endinterface

/* src/svs_rsp_if.sv */
// ----------------------------------------------------------------------------
// svs_rsp_if: response channel of the sorted value store
// Valid/ready channel carrying the status and read data of one operation.
// ----------------------------------------------------------------------------
interface svs_rsp_if;

    logic               valid;
    logic               ready;
    logic               ok;
    logic signed [31:0] read_value;
    logic [6:0]         entry_count;
    logic               is_empty;

    modport source (output valid, output ok, output read_value, output entry_count,
                    output is_empty, input ready);
    modport sink   (input valid, input ok, input read_value, input entry_count,
                    input is_empty, output ready);

endinterface

/* src/svs_cell.sv */
// ----------------------------------------------------------------------------
// svs_cell: one storage cell of the sorted value store
// Holds one entry, compares it against the broadcast value and index, and
// takes a neighbor's entry when the row shifts for an insert or a removal.
// ----------------------------------------------------------------------------
module svs_cell
    import svs_pkg::*;
(
    input  logic                     clk,
    input  cell_ctl_t                ctl,
    input  logic [CMP_W-1:0]         pos,
    input  logic signed [DATA_W-1:0] left_value,
    input  logic                     left_lt,
    input  logic signed [DATA_W-1:0] right_value,
    output logic signed [DATA_W-1:0] value,
    output logic                     lt,
    output logic                     found,
    output logic [DATA_W-1:0]        read_data
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     in_use;
    logic                     hit;

    assign in_use = pos < ctl.count;
    assign lt     = in_use && (value_reg < ctl.value);

    // The entry holding the first position not below the value is the only
    // candidate for removal, since the row is kept in ascending order.
    assign found     = in_use && !lt && left_lt && (value_reg == ctl.value);
    assign hit       = in_use && (pos == ctl.index);
    assign read_data = hit ? value_reg : '0;
    assign value     = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.commit)
        begin
            unique case (ctl.op)
                OP_INSERT:
                begin
                    if (!lt)
                    begin
                        value_next = left_lt ? ctl.value : left_value;
                    end
                end
                OP_REMOVE_AT:
                begin
                    if (pos >= ctl.index)
                    begin
                        value_next = right_value;
                    end
                end
                OP_REMOVE_VAL:
                begin
                    if (!lt)
                    begin
                        value_next = right_value;
                    end
                end
                OP_READ:
                begin
                    value_next = value_reg;
                end
                default:
                begin
                    value_next = value_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

/* src/svs_merge.sv */
// ----------------------------------------------------------------------------
// svs_merge: result collection across the cell row
// ORs the per-cell match flags and the masked read data into single results.
// ----------------------------------------------------------------------------
module svs_merge
    import svs_pkg::*;
(
    input  logic [CAPACITY-1:0]           found_vec,
    input  logic [CAPACITY-1:0][DATA_W-1:0] read_vec,
    output logic                          found_any,
    output logic [DATA_W-1:0]             read_any
);

    // At most one cell drives nonzero read data, so an OR acts as the select.
    always_comb
    begin
        read_any = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            read_any = read_any | read_vec[i];
        end
    end

    assign found_any = |found_vec;

endmodule

/* src/sorted_value_store_unit.sv */
// ----------------------------------------------------------------------------
// sorted_value_store_unit: sorted table of signed values in a row of cells
// Keeps up to CAPACITY entries in ascending order with duplicates allowed.
//
// Requests arrive on the req channel: insert a value, remove at an index,
// remove one entry equal to a value, or read at an index. Each request gives
// exactly one response on the rsp channel with the success flag, the read
// value, the entry count afterwards and an empty flag.
// A transfer on req is latched into a command register; once the output
// register can take a response, every cell compares its entry against the
// command in parallel, the row shifts by one place toward or away from the
// insert or removal point, and the response is loaded into the output
// register, which drives rsp. One request is taken every cycle as long as
// responses are taken; the cell row's compare, the match OR across all cells
// and the shift select form the combinational path of that step.
// When rsp is stalled, the command register holds and req stops taking
// transfers once both the command and output registers are full.
// Reset clears the count, so the store starts empty; entries are not reset.
// ----------------------------------------------------------------------------
module sorted_value_store_unit
    import svs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    svs_req_if.sink   req,
    svs_rsp_if.source rsp
);

    logic                     cmd_valid_reg;
    logic                     cmd_valid_next;
    op_t                      cmd_op_reg;
    logic signed [DATA_W-1:0] cmd_value_reg;
    logic [IDX_W-1:0]         cmd_index_reg;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     out_ok_reg;
    logic signed [DATA_W-1:0] out_read_reg;
    logic [COUNT_W-1:0]       out_count_reg;
    logic                     out_empty_reg;

    logic                     advance;
    logic                     in_take;
    logic                     is_full;
    logic                     index_ok;
    logic                     op_ok;
    logic [CMP_W-1:0]         index_ext;
    logic [EXT_W-1:0]         count_ext;
    cell_ctl_t                ctl;

    logic [CAPACITY-1:0][DATA_W-1:0] cell_value;
    logic [CAPACITY-1:0]             cell_lt;
    logic [CAPACITY-1:0]             cell_found;
    logic [CAPACITY-1:0][DATA_W-1:0] cell_read;
    logic                            found_any;
    logic [DATA_W-1:0]               read_any;

    assign advance   = cmd_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !cmd_valid_reg || advance;
    assign in_take   = req.valid && req.ready;

    assign index_ext = CMP_W'(cmd_index_reg);
    assign is_full   = count_reg == CNT_W'(CAPACITY);
    assign index_ok  = index_ext < CMP_W'(count_reg);

    always_comb
    begin
        unique case (cmd_op_reg)
            OP_INSERT:     op_ok = !is_full;
            OP_REMOVE_AT:  op_ok = index_ok;
            OP_REMOVE_VAL: op_ok = found_any;
            OP_READ:       op_ok = index_ok;
            default:       op_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (advance && op_ok)
        begin
            unique case (cmd_op_reg)
                OP_INSERT:     count_next = count_reg + 1'b1;
                OP_REMOVE_AT:  count_next = count_reg - 1'b1;
                OP_REMOVE_VAL: count_next = count_reg - 1'b1;
                OP_READ:       count_next = count_reg;
                default:       count_next = count_reg;
            endcase
        end
    end

    assign count_ext = EXT_W'(count_next);

    assign ctl.op     = cmd_op_reg;
    assign ctl.value  = cmd_value_reg;
    assign ctl.index  = index_ext;
    assign ctl.count  = CMP_W'(count_reg);
    assign ctl.commit = advance && op_ok && (cmd_op_reg != OP_READ);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_value;
        logic                     left_lt;
        logic signed [DATA_W-1:0] right_value;

        // Everything before the first cell counts as less than any value.
        if (i == 0)
        begin : g_first
            assign left_value = '0;
            assign left_lt    = 1'b1;
        end
        else
        begin : g_inner
            assign left_value = cell_value[i-1];
            assign left_lt    = cell_lt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_value = '0;
        end
        else
        begin : g_body
            assign right_value = cell_value[i+1];
        end

        svs_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .pos         (CMP_W'(i)),
            .left_value  (left_value),
            .left_lt     (left_lt),
            .right_value (right_value),
            .value       (cell_value[i]),
            .lt          (cell_lt[i]),
            .found       (cell_found[i]),
            .read_data   (cell_read[i])
        );
    end

    svs_merge u_merge (
        .found_vec (cell_found),
        .read_vec  (cell_read),
        .found_any (found_any),
        .read_any  (read_any)
    );

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (in_take)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (advance)
        begin
            cmd_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_op_reg    <= op_t'(req.opcode);
            cmd_value_reg <= req.value;
            cmd_index_reg <= req.index;
        end
        if (advance)
        begin
            out_ok_reg    <= op_ok;
            out_read_reg  <= (cmd_op_reg == OP_READ) ? read_any : '0;
            out_count_reg <= count_ext[COUNT_W-1:0];
            out_empty_reg <= count_next == '0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = out_ok_reg;
    assign rsp.read_value  = out_read_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.is_empty    = out_empty_reg;

endmodule
